// ----- design/cube_sphere_vertex_generator_defines.svh -----
// assertion macros for the cube sphere vertex generator
`ifndef CUBE_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define CUBE_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define CSVG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("csvg assertion failed");
`define CSVG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("csvg reset assertion failed");
`else
`define CSVG_ASSERT(lbl, prop)
`define CSVG_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- design/csvg_pkg.sv -----
// types, constants and tables shared by the cube sphere vertex generator
package csvg_pkg;

  localparam int MAX_SUBDIVISION_DEF = 8;
  localparam int OUT_FRAC_BITS_DEF   = 14;

  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam int ZW           = 33;
  localparam int CRW          = 34;
  localparam int SQW          = 64;
  localparam int SQRT_STEPS   = 32;
  localparam int NORMW        = 32;
  localparam int REMW         = 64;
  localparam int QUOW         = 32;
  localparam int OUTW         = 16;
  localparam int LVLW         = 4;

  localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(652032874);
  localparam logic signed [ZW-1:0] ANGLE_45     = ZW'(64'd1 << 29);
  localparam logic [LVLW-1:0]      SUBDIV_RESET = 4'd3;
  localparam logic [2:0]           LAST_FACE    = 3'd5;

  typedef enum logic [2:0] {
    SEL_ZERO = 3'd0,
    SEL_PSIN = 3'd1,
    SEL_NSIN = 3'd2,
    SEL_PCOS = 3'd3,
    SEL_NCOS = 3'd4
  } sel_e;

  typedef struct packed {
    logic [2:0] face_select;
    logic [8:0] row_index;
    logic [8:0] column_index;
  } in_t;

  typedef struct packed {
    logic signed [OUTW-1:0] vec_x;
    logic signed [OUTW-1:0] vec_y;
    logic signed [OUTW-1:0] vec_z;
    logic                   bad_input;
  } out_t;

  typedef struct packed {
    logic [2:0]           face;
    logic                 bad;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [ZW-1:0] z1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [ZW-1:0] z2;
  } cord_t;

  typedef struct packed {
    logic                      bad;
    logic [2:0][CRW-1:0]       cr;
    logic [SQW-1:0]            v;
    logic [SQW-1:0]            r;
  } sq_t;

  typedef struct packed {
    logic                 bad;
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][REMW-1:0] rem;
    logic [2:0][QUOW-1:0] quo;
    logic [NORMW-1:0]     norm;
  } dv_t;

  function automatic int atan_angle(int i);
    int a;
    case (i)
      0:  a = 536870912;
      1:  a = 316933406;
      2:  a = 167458907;
      3:  a = 85004756;
      4:  a = 42667331;
      5:  a = 21354465;
      6:  a = 10679838;
      7:  a = 5340245;
      8:  a = 2670163;
      9:  a = 1335087;
      10: a = 667544;
      11: a = 333772;
      12: a = 166886;
      13: a = 83443;
      14: a = 41722;
      15: a = 20861;
      16: a = 10430;
      17: a = 5215;
      18: a = 2608;
      19: a = 1304;
      20: a = 652;
      21: a = 326;
      22: a = 163;
      23: a = 81;
      24: a = 41;
      25: a = 20;
      26: a = 10;
      27: a = 5;
      28: a = 3;
      29: a = 1;
      default: a = 0;
    endcase
    return a;
  endfunction

  // plane normal sign table, per face and angle
  function automatic sel_e normal_sel(logic [2:0] f, logic side, logic [1:0] axis);
    sel_e row [3];
    case ({f, side})
      {3'd0, 1'b0}: row = '{SEL_NSIN, SEL_ZERO, SEL_NCOS};
      {3'd0, 1'b1}: row = '{SEL_NSIN, SEL_PCOS, SEL_ZERO};
      {3'd1, 1'b0}: row = '{SEL_NCOS, SEL_ZERO, SEL_PSIN};
      {3'd1, 1'b1}: row = '{SEL_ZERO, SEL_PCOS, SEL_PSIN};
      {3'd2, 1'b0}: row = '{SEL_PSIN, SEL_ZERO, SEL_PCOS};
      {3'd2, 1'b1}: row = '{SEL_PSIN, SEL_PCOS, SEL_ZERO};
      {3'd3, 1'b0}: row = '{SEL_PCOS, SEL_ZERO, SEL_NSIN};
      {3'd3, 1'b1}: row = '{SEL_ZERO, SEL_PCOS, SEL_NSIN};
      {3'd4, 1'b0}: row = '{SEL_NCOS, SEL_PSIN, SEL_ZERO};
      {3'd4, 1'b1}: row = '{SEL_ZERO, SEL_PSIN, SEL_NCOS};
      {3'd5, 1'b0}: row = '{SEL_PCOS, SEL_NSIN, SEL_ZERO};
      {3'd5, 1'b1}: row = '{SEL_ZERO, SEL_NSIN, SEL_NCOS};
      default:      row = '{SEL_ZERO, SEL_ZERO, SEL_ZERO};
    endcase
    return (axis == 2'd0) ? row[0] : ((axis == 2'd1) ? row[1] : row[2]);
  endfunction

  function automatic logic signed [CW-1:0] pick(sel_e sel, logic signed [CW-1:0] s,
                                                 logic signed [CW-1:0] c);
    logic signed [CW-1:0] v;
    case (sel)
      SEL_PSIN: v = s;
      SEL_NSIN: v = -s;
      SEL_PCOS: v = c;
      SEL_NCOS: v = -c;
      default:  v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/csvg_cordic_cell.sv -----
// one rotation step of the two sine/cosine chains
module csvg_cordic_cell import csvg_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cord_t data_i,
  output logic  valid_o,
  output cord_t data_o
);

  localparam logic signed [ZW-1:0] AT = ZW'(atan_angle(STEP));

  logic  valid_q;
  cord_t data_q, data_d;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic signed [ZW-1:0] z1, z2;

  always_comb begin
    x1 = data_i.x1;
    y1 = data_i.y1;
    z1 = data_i.z1;
    x2 = data_i.x2;
    y2 = data_i.y2;
    z2 = data_i.z2;
    data_d = data_i;
    if (!z1[ZW-1]) begin
      data_d.x1 = x1 - (y1 >>> STEP);
      data_d.y1 = y1 + (x1 >>> STEP);
      data_d.z1 = z1 - AT;
    end else begin
      data_d.x1 = x1 + (y1 >>> STEP);
      data_d.y1 = y1 - (x1 >>> STEP);
      data_d.z1 = z1 + AT;
    end
    if (!z2[ZW-1]) begin
      data_d.x2 = x2 - (y2 >>> STEP);
      data_d.y2 = y2 + (x2 >>> STEP);
      data_d.z2 = z2 - AT;
    end else begin
      data_d.x2 = x2 + (y2 >>> STEP);
      data_d.y2 = y2 - (x2 >>> STEP);
      data_d.z2 = z2 + AT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/csvg_cross.sv -----
// normal selection, cross product and sum of squares
module csvg_cross import csvg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cord_t data_i,
  output logic  valid_o,
  output sq_t   data_o
);

  logic [3:0] valid_q;
  logic       bad1_q, bad2_q, bad3_q, bad4_q;
  logic signed [2:0][SQW-1:0] pa_q, pb_q;
  logic [2:0][CRW-1:0] cr2_q, cr3_q, cr4_q;
  logic [2:0][SQW-1:0] sqr_q;
  logic [SQW-1:0]      sum_q;

  logic signed [CW-1:0] n1 [3];
  logic signed [CW-1:0] n2 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n1[k] = pick(normal_sel(data_i.face, 1'b0, 2'(k)), data_i.y1, data_i.x1);
      n2[k] = pick(normal_sel(data_i.face, 1'b1, 2'(k)), data_i.y2, data_i.x2);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int J = (k + 1) % 3;
    localparam int L = (k + 2) % 3;
    logic signed [SQW-1:0] diff;
    logic signed [CRW-1:0] cr;
    logic [NORMW-1:0]      mag;
    logic [SQW-1:0]        sq;

    assign diff = $signed(pa_q[k]) - $signed(pb_q[k]);
    assign cr   = $signed(cr2_q[k]);
    assign mag  = NORMW'(cr[CRW-1] ? -cr : cr);
    assign sq   = mag * mag;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[k]  <= SQW'(n1[J]) * SQW'(n2[L]);
        pb_q[k]  <= SQW'(n1[L]) * SQW'(n2[J]);
        cr2_q[k] <= CRW'(diff >>> 30);
        cr3_q[k] <= cr2_q[k];
        sqr_q[k] <= sq;
        cr4_q[k] <= cr3_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad1_q <= data_i.bad;
      bad2_q <= bad1_q;
      bad3_q <= bad2_q;
      bad4_q <= bad3_q;
      sum_q  <= sqr_q[0] + sqr_q[1] + sqr_q[2];
    end
  end

  assign valid_o     = valid_q[3];
  assign data_o.bad  = bad4_q;
  assign data_o.cr   = cr4_q;
  assign data_o.v    = sum_q;
  assign data_o.r    = '0;

endmodule

// ----- design/csvg_sqrt_cell.sv -----
// one result bit of the integer square root
module csvg_sqrt_cell import csvg_pkg::*; #(
  parameter int K = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sq_t  data_i,
  output logic valid_o,
  output sq_t  data_o
);

  localparam logic [SQW-1:0] BIT = SQW'(1) << (62 - 2 * K);

  logic valid_q;
  sq_t  data_q, data_d;
  logic [SQW-1:0] t;

  always_comb begin
    t = data_i.r + BIT;
    data_d = data_i;
    if (data_i.v >= t) begin
      data_d.v = data_i.v - t;
      data_d.r = (data_i.r >> 1) + BIT;
    end else begin
      data_d.r = data_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/csvg_div_cell.sv -----
// one quotient bit of the three normalizing divisions
module csvg_div_cell import csvg_pkg::*; #(
  parameter int K = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  dv_t  data_i,
  output logic valid_o,
  output dv_t  data_o
);

  logic valid_q;
  dv_t  data_q, data_d;
  logic [REMW-1:0] d;

  always_comb begin
    d = REMW'(data_i.norm) << K;
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      if (data_i.rem[k] >= d) begin
        data_d.rem[k]    = data_i.rem[k] - d;
        data_d.quo[k][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/cube_sphere_vertex_generator.sv -----
// top level of the cube sphere vertex generator
//
//   channel  | signals                             | direction
//   ---------+-------------------------------------+----------
//   input    | in_valid_i, in_stall_o, in_data_i   | in
//   output   | out_valid_o, out_stall_i, out_data_o| out
//   config   | cfg_we_i, cfg_data_i                | in
//
// one transaction per cycle while the output register is not both full and stalled;
// data passes the cordic, cross, square root, prep, divider and output registers
// the whole pipeline advances together; it holds only while the output register
// is full and stalled
// reset clears the valid bits and sets subdivision_level to 3
`include "cube_sphere_vertex_generator_defines.svh"
module cube_sphere_vertex_generator import csvg_pkg::*; #(
  parameter int MAX_SUBDIVISION = MAX_SUBDIVISION_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o,
  input  logic            cfg_we_i,
  input  logic [LVLW-1:0] cfg_data_i
);

  localparam int QW = OUT_FRAC_BITS + 2;
  localparam logic signed [OUTW:0] LIM_P =
    (OUT_FRAC_BITS >= 15) ? 17'sd32767 : 17'(1 << OUT_FRAC_BITS);
  localparam logic signed [OUTW:0] LIM_N =
    (OUT_FRAC_BITS >= 15) ? -17'sd32768 : -17'(1 << OUT_FRAC_BITS);

  logic            en;
  logic [LVLW-1:0] subdiv_q;
  logic [LVLW-1:0] lvl;
  logic [10:0]     last;
  logic [38:0]     row_w, col_w;
  cord_t           cord_in;

  logic  cord_v [CORDIC_STEPS+1];
  cord_t cord_d [CORDIC_STEPS+1];
  logic  sq_v   [SQRT_STEPS+1];
  sq_t   sq_d   [SQRT_STEPS+1];
  logic  dv_v   [QW+1];
  dv_t   dv_d   [QW+1];

  logic  prep_v_q;
  dv_t   prep_q, prep_d;
  logic  out_valid_q;
  out_t  out_q, out_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= SUBDIV_RESET;
    end else if (cfg_we_i) begin
      subdiv_q <= cfg_data_i;
    end
  end

  always_comb begin
    lvl   = (subdiv_q > LVLW'(MAX_SUBDIVISION)) ? LVLW'(MAX_SUBDIVISION) : subdiv_q;
    last  = 11'(1) << lvl;
    row_w = {in_data_i.row_index, 30'b0} >> lvl;
    col_w = {in_data_i.column_index, 30'b0} >> lvl;
    cord_in.face = in_data_i.face_select;
    cord_in.bad  = (in_data_i.face_select > LAST_FACE) ||
                   (11'(in_data_i.row_index) > last) ||
                   (11'(in_data_i.column_index) > last);
    cord_in.x1 = CORDIC_GAIN;
    cord_in.y1 = '0;
    cord_in.z1 = $signed(ZW'(col_w)) - ANGLE_45;
    cord_in.x2 = CORDIC_GAIN;
    cord_in.y2 = '0;
    cord_in.z2 = ANGLE_45 - $signed(ZW'(row_w));
  end

  assign cord_v[0] = in_valid_i;
  assign cord_d[0] = cord_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    csvg_cordic_cell #(.STEP(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cord_v[i]), .data_i(cord_d[i]),
      .valid_o(cord_v[i+1]), .data_o(cord_d[i+1])
    );
  end

  csvg_cross u_cross (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(cord_v[CORDIC_STEPS]), .data_i(cord_d[CORDIC_STEPS]),
    .valid_o(sq_v[0]), .data_o(sq_d[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    csvg_sqrt_cell #(.K(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sq_v[i]), .data_i(sq_d[i]),
      .valid_o(sq_v[i+1]), .data_o(sq_d[i+1])
    );
  end

  always_comb begin
    logic signed [CRW-1:0] c;
    logic [REMW-1:0]       mag;
    logic [NORMW-1:0]      norm;
    norm = sq_d[SQRT_STEPS].r[NORMW-1:0];
    prep_d.bad  = sq_d[SQRT_STEPS].bad;
    prep_d.zero = (norm == '0);
    prep_d.norm = norm;
    prep_d.quo  = '0;
    for (int k = 0; k < 3; k++) begin
      c = $signed(sq_d[SQRT_STEPS].cr[k]);
      mag = REMW'(c[CRW-1] ? -c : c);
      prep_d.neg[k] = c[CRW-1];
      prep_d.rem[k] = (mag << OUT_FRAC_BITS) + REMW'(norm >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  assign dv_v[0] = prep_v_q;
  assign dv_d[0] = prep_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    csvg_div_cell #(.K(QW - 1 - i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv_v[i]), .data_i(dv_d[i]),
      .valid_o(dv_v[i+1]), .data_o(dv_d[i+1])
    );
  end

  always_comb begin
    logic [QUOW-1:0]       q;
    logic signed [OUTW-1:0] v [3];
    for (int k = 0; k < 3; k++) begin
      q = dv_d[QW].quo[k];
      if (dv_d[QW].neg[k]) begin
        v[k] = (q >= QUOW'(32768)) ? -16'sd32768 : -$signed(OUTW'(q));
      end else begin
        v[k] = (q >= QUOW'(32767)) ? 16'sd32767 : $signed(OUTW'(q));
      end
      if (dv_d[QW].bad || dv_d[QW].zero) begin
        v[k] = '0;
      end
    end
    out_d.vec_x     = v[0];
    out_d.vec_y     = v[1];
    out_d.vec_z     = v[2];
    out_d.bad_input = dv_d[QW].bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CSVG_ASSERT(a_bad_zero, out_valid_o && out_data_o.bad_input |-> out_data_o.vec_x == '0 && out_data_o.vec_y == '0 && out_data_o.vec_z == '0)
  `CSVG_ASSERT(a_unit_range, out_valid_o |-> 17'(out_data_o.vec_x) <= LIM_P && 17'(out_data_o.vec_x) >= LIM_N && 17'(out_data_o.vec_z) <= LIM_P && 17'(out_data_o.vec_z) >= LIM_N)
  `CSVG_ASSERT_RST(a_cfg_reset, !rst_ni |=> subdiv_q == SUBDIV_RESET)

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the cube sphere vertex generator
module tb_top;
  import csvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_LVL      = 8;
  localparam int FRAC_BITS    = 14;
  localparam int IN_W         = $bits(in_t);

  localparam longint ATAN_TAB [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  localparam sel_e FACE_NORMALS [6][2][3] = '{
    '{'{SEL_NSIN, SEL_ZERO, SEL_NCOS}, '{SEL_NSIN, SEL_PCOS, SEL_ZERO}},
    '{'{SEL_NCOS, SEL_ZERO, SEL_PSIN}, '{SEL_ZERO, SEL_PCOS, SEL_PSIN}},
    '{'{SEL_PSIN, SEL_ZERO, SEL_PCOS}, '{SEL_PSIN, SEL_PCOS, SEL_ZERO}},
    '{'{SEL_PCOS, SEL_ZERO, SEL_NSIN}, '{SEL_ZERO, SEL_PCOS, SEL_NSIN}},
    '{'{SEL_NCOS, SEL_PSIN, SEL_ZERO}, '{SEL_ZERO, SEL_PSIN, SEL_NCOS}},
    '{'{SEL_PCOS, SEL_NSIN, SEL_ZERO}, '{SEL_ZERO, SEL_NSIN, SEL_NCOS}}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [LVLW-1:0] cfg_data_i = '0;

  out_t        vertex_q [$];
  logic [3:0]  level_reg = SUBDIV_RESET;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          sent_items = 0;
  int          checked_items = 0;
  int          bad_items = 0;
  int          cycles = 0;

  cube_sphere_vertex_generator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_data_i
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint select_term(sel_e sel, longint s, longint c);
    case (sel)
      SEL_PSIN: return s;
      SEL_NSIN: return -s;
      SEL_PCOS: return c;
      SEL_NCOS: return -c;
      default:  return 0;
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_q14(longint comp, longint unsigned norm);
    longint unsigned mag, q;
    longint v;
    mag = (comp < 0) ? -comp : comp;
    q = ((mag << FRAC_BITS) + (norm >> 1)) / norm;
    if (q > 32768) q = 32768;
    v = (comp < 0) ? -longint'(q) : longint'(q);
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  function automatic out_t predict_vertex(in_t item, logic [3:0] lvl_in);
    out_t r;
    int lvl;
    longint unsigned last, sq, norm;
    longint a1, a2, s1, c1, s2, c2;
    longint n1 [3], n2 [3], cr [3];
    lvl = (lvl_in > MAX_LVL) ? MAX_LVL : lvl_in;
    last = 64'd1 << lvl;
    r = '0;
    r.bad_input = 1'b1;
    if (item.face_select > LAST_FACE || item.row_index > last || item.column_index > last)
      return r;
    a2 = (longint'(1) << 29) - (longint'(item.row_index) << (30 - lvl));
    a1 = (longint'(item.column_index) << (30 - lvl)) - (longint'(1) << 29);
    sin_cos(a1, s1, c1);
    sin_cos(a2, s2, c2);
    for (int k = 0; k < 3; k++) begin
      n1[k] = select_term(FACE_NORMALS[item.face_select][0][k], s1, c1);
      n2[k] = select_term(FACE_NORMALS[item.face_select][1][k], s2, c2);
    end
    cr[0] = (n1[1] * n2[2] - n1[2] * n2[1]) >>> 30;
    cr[1] = (n1[2] * n2[0] - n1[0] * n2[2]) >>> 30;
    cr[2] = (n1[0] * n2[1] - n1[1] * n2[0]) >>> 30;
    sq = 0;
    for (int k = 0; k < 3; k++) sq += longint'(cr[k] * cr[k]);
    norm = int_sqrt(sq);
    r.bad_input = 1'b0;
    if (norm == 0) return r;
    r.vec_x = scale_q14(cr[0], norm);
    r.vec_y = scale_q14(cr[1], norm);
    r.vec_z = scale_q14(cr[2], norm);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    out_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_items <= checked_items + 1;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", out_data_o);
      end else begin
        exp_v = vertex_q.pop_front();
        if (out_data_o !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%0d y=%0d z=%0d bad=%b got x=%0d y=%0d z=%0d bad=%b",
                     exp_v.vec_x, exp_v.vec_y, exp_v.vec_z, exp_v.bad_input,
                     out_data_o.vec_x, out_data_o.vec_y, out_data_o.vec_z,
                     out_data_o.bad_input);
        end
      end
    end
  end

  task automatic send_vertex(in_t item);
    out_t exp_v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    exp_v = predict_vertex(item, level_reg);
    vertex_q = {vertex_q, exp_v};
    sent_items++;
    if (exp_v.bad_input) bad_items++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_level(logic [3:0] lvl);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= lvl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    level_reg = lvl;
  endtask

  function automatic in_t make_item(int f, int r, int c);
    in_t it;
    it.face_select  = 3'(f);
    it.row_index    = 9'(r);
    it.column_index = 9'(c);
    return it;
  endfunction

  task automatic test_reset_level();
    send_vertex(make_item(0, 8, 8));
    send_vertex(make_item(1, 9, 0));
    send_vertex(make_item(2, 0, 9));
  endtask

  task automatic test_directed();
    logic [3:0] lvls [3] = '{4'd0, 4'd8, 4'd15};
    int lst;
    for (int i = 0; i < 3; i++) begin
      set_level(lvls[i]);
      lst = 1 << ((level_reg > MAX_LVL) ? MAX_LVL : level_reg);
      for (int f = 0; f < 8; f++) send_vertex(make_item(f, 0, lst));
      send_vertex(make_item(3, lst, 0));
      send_vertex(make_item(4, lst + 1, 0));
      send_vertex(make_item(5, 0, lst + 1));
      send_vertex(make_item(0, 511, 511));
    end
  endtask

  task automatic test_random(int items);
    int lst;
    in_t it;
    for (int n = 0; n < items; n++) begin
      if (n % 100 == 0) set_level(4'($urandom_range(9) == 0 ? $urandom_range(15, 9)
                                                              : $urandom_range(8)));
      lst = 1 << ((level_reg > MAX_LVL) ? MAX_LVL : level_reg);
      if ($urandom_range(9) < 8) begin
        it = make_item($urandom_range(5), $urandom_range(lst), $urandom_range(lst));
      end else begin
        it = IN_W'($urandom);
      end
      send_vertex(it);
      if (n == items / 2) wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_level();
    test_directed();
    send_idle_pct = 29; recv_idle_pct = 68;
    test_random(580);
    send_idle_pct = 68; recv_idle_pct = 29;
    test_random(580);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(580);
    wait_idle();
    $display("sent %0d vertices (%0d out of range), checked %0d results",
             sent_items, bad_items, checked_items);
    $display("levels 0..15 with directed corners, faces and bad inputs");
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/csvg_pkg.sv
design/csvg_cordic_cell.sv
design/csvg_cross.sv
design/csvg_sqrt_cell.sv
design/csvg_div_cell.sv
design/cube_sphere_vertex_generator.sv
sim/tb_top.sv
